// ===== rtl/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_LT  = 3'd4,
    ACT_EQ  = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_GCD,
    S_GCD_WAIT,
    S_DIVN,
    S_DIVD,
    S_CHK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic [1:0]         status;
  } out_t;

endpackage

// ===== rtl/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier and result register.
// The unit takes one request at a time: an action and two rationals a_num/a_den and
// b_num/b_den, of which only the low OPERAND_WIDTH bits are used, sign-extended. A single
// OPERAND_WIDTH-by-OPERAND_WIDTH magnitude multiplier forms the three products in the states
// S_MUL0, S_MUL1 and S_MUL2; S_COMB then combines them (add, subtract, multiply, divide, or
// the less-than and equal tests), and the result is then reduced by the Euclidean GCD. All
// remainders of the Euclidean loop and the two final exact divisions run through one shared
// restoring divider of 2*OPERAND_WIDTH bits. Comparisons, division by zero and a zero result
// denominator skip the reduction and go straight to the result. The unit passes through
// idle before the next request is taken.
// in_ready_o is high only while the unit is idle. The result is held in an output register
// until taken; the unit returns to idle as soon as the result is loaded. A zero result
// denominator gives zero fields with status ok, a divide by a zero numerator gives status 1,
// and a reduced result that does not fit OPERAND_WIDTH bits gives status 2 with zero fields.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rau_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::out_t out_res_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;

  rau_pkg::state_e state_q, state_d;
  rau_pkg::act_e   act_q;

  // Operand magnitudes and signs: 0 a_num, 1 a_den, 2 b_num, 3 b_den.
  logic [W-1:0]  mag_q [4];
  logic          neg_q [4];
  logic [PW-1:0] prod_q [3];
  logic          pneg_q [3];

  logic [PW-1:0] nmag_q, nmag_d, dmag_q, dmag_d;
  logic [PW-1:0] ga_q, ga_d, gb_q, gb_d, g_q, g_d;
  logic          rneg_q, rneg_d;
  rau_pkg::out_t res_q, res_d, out_q;
  logic          out_valid_q;

  // Multiplier operand select.
  logic [W-1:0]  mul_x, mul_y;
  logic          mul_nx, mul_ny;
  logic [PW-1:0] mul_p;
  logic [1:0]    mul_idx;
  logic          mul_en;

  // Divider hookup.
  logic          div_start, div_done;
  logic [PW-1:0] div_dvd, div_dvs, div_quo, div_rem;

  // Capture of incoming operands.
  logic [W-1:0]  in_mag [4];
  logic          in_neg [4];
  logic [W-1:0]  in_raw [4];

  assign in_raw[0] = in_req_i.a_num[W-1:0];
  assign in_raw[1] = in_req_i.a_den[W-1:0];
  assign in_raw[2] = in_req_i.b_num[W-1:0];
  assign in_raw[3] = in_req_i.b_den[W-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_neg[i] = in_raw[i][W-1];
      in_mag[i] = in_neg[i] ? (~in_raw[i] + 1'b1) : in_raw[i];
    end
  end

  assign in_ready_o = (state_q == rau_pkg::S_IDLE);

  always_comb begin
    mul_en  = 1'b1;
    mul_idx = 2'd0;
    mul_x   = mag_q[0];
    mul_nx  = neg_q[0];
    mul_y   = (act_q == rau_pkg::ACT_MUL) ? mag_q[2] : mag_q[3];
    mul_ny  = (act_q == rau_pkg::ACT_MUL) ? neg_q[2] : neg_q[3];
    case (state_q)
      rau_pkg::S_MUL0: begin
        mul_idx = 2'd0;
      end
      rau_pkg::S_MUL1: begin
        mul_idx = 2'd1;
        mul_x   = mag_q[2];
        mul_nx  = neg_q[2];
        mul_y   = mag_q[1];
        mul_ny  = neg_q[1];
      end
      rau_pkg::S_MUL2: begin
        mul_idx = 2'd2;
        mul_x   = mag_q[1];
        mul_nx  = neg_q[1];
        mul_y   = mag_q[3];
        mul_ny  = neg_q[3];
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  rau_div #(
    .DW(PW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Combine stage terms.
  logic          xs, ys, zs, qn, sub_op, pm_ge;
  logic [PW-1:0] pm, qm;
  logic signed [PW:0] lhs, rhs;
  logic          sa, sb;
  logic [PW-1:0] lim, nlim, ovf_num;

  always_comb begin
    xs     = pneg_q[0] && (prod_q[0] != '0);
    ys     = pneg_q[1] && (prod_q[1] != '0);
    zs     = pneg_q[2] && (prod_q[2] != '0);
    sub_op = (act_q == rau_pkg::ACT_SUB);
    qn     = ys ^ sub_op;
    pm     = prod_q[0];
    qm     = prod_q[1];
    pm_ge  = (pm >= qm);
    sa     = (mag_q[0] != '0) && (mag_q[1] != '0) && (neg_q[0] == neg_q[1]);
    sb     = (mag_q[2] != '0) && (mag_q[3] != '0) && (neg_q[2] == neg_q[3]);
    lhs    = sa ? $signed({1'b0, prod_q[0]}) : -$signed({1'b0, prod_q[0]});
    rhs    = sb ? $signed({1'b0, prod_q[1]}) : -$signed({1'b0, prod_q[1]});
    lim    = PW'(1) << (W - 1);
    nlim   = rneg_q ? lim : (lim - 1'b1);
    ovf_num = rneg_q ? (~nmag_q + 1'b1) : nmag_q;
  end

  always_comb begin
    state_d   = state_q;
    nmag_d    = nmag_q;
    dmag_d    = dmag_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    g_d       = g_q;
    rneg_d    = rneg_q;
    res_d     = res_q;
    div_start = 1'b0;
    div_dvd   = gb_q;
    div_dvs   = ga_q;
    case (state_q)
      rau_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = rau_pkg::S_MUL0;
        end
      end
      rau_pkg::S_MUL0: state_d = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_d = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: state_d = rau_pkg::S_COMB;
      rau_pkg::S_COMB: begin
        res_d   = '0;
        state_d = rau_pkg::S_FIN;
        case (act_q)
          rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            if (xs == qn) begin
              nmag_d = pm + qm;
              rneg_d = xs ^ zs;
            end else if (pm_ge) begin
              nmag_d = pm - qm;
              rneg_d = xs ^ zs;
            end else begin
              nmag_d = qm - pm;
              rneg_d = qn ^ zs;
            end
            dmag_d = prod_q[2];
          end
          rau_pkg::ACT_MUL: begin
            nmag_d = prod_q[0];
            rneg_d = xs ^ zs;
            dmag_d = prod_q[2];
          end
          rau_pkg::ACT_DIV: begin
            nmag_d = prod_q[0];
            rneg_d = xs ^ ys;
            dmag_d = prod_q[1];
          end
          rau_pkg::ACT_LT: begin
            res_d.compare_true = (lhs < rhs);
          end
          rau_pkg::ACT_EQ: begin
            res_d.compare_true = (prod_q[0] == prod_q[1]) &&
                                 ((prod_q[0] == '0) || (pneg_q[0] == pneg_q[1]));
          end
          default: begin
          end
        endcase
        if (act_q == rau_pkg::ACT_DIV && mag_q[2] == '0) begin
          res_d.status = rau_pkg::ST_DIV_ZERO;
        end else if (act_q == rau_pkg::ACT_ADD || act_q == rau_pkg::ACT_SUB ||
                     act_q == rau_pkg::ACT_MUL || act_q == rau_pkg::ACT_DIV) begin
          if (dmag_d != '0) begin
            ga_d    = nmag_d;
            gb_d    = dmag_d;
            state_d = rau_pkg::S_GCD;
          end
        end
      end
      rau_pkg::S_GCD: begin
        div_start = 1'b1;
        if (ga_q != '0) begin
          state_d = rau_pkg::S_GCD_WAIT;
        end else begin
          div_dvd = nmag_q;
          div_dvs = gb_q;
          g_d     = gb_q;
          state_d = rau_pkg::S_DIVN;
        end
      end
      rau_pkg::S_GCD_WAIT: begin
        if (div_done) begin
          gb_d    = ga_q;
          ga_d    = div_rem;
          state_d = rau_pkg::S_GCD;
        end
      end
      rau_pkg::S_DIVN: begin
        div_dvd = dmag_q;
        div_dvs = g_q;
        if (div_done) begin
          nmag_d    = div_quo;
          div_start = 1'b1;
          state_d   = rau_pkg::S_DIVD;
        end
      end
      rau_pkg::S_DIVD: begin
        if (div_done) begin
          dmag_d  = div_quo;
          state_d = rau_pkg::S_CHK;
        end
      end
      rau_pkg::S_CHK: begin
        res_d = '0;
        if (dmag_q > (lim - 1'b1) || nmag_q > nlim) begin
          res_d.status = rau_pkg::ST_OVERFLOW;
        end else begin
          res_d.res_num = 32'($signed(ovf_num[W-1:0]));
          res_d.res_den = 31'(dmag_q);
        end
        state_d = rau_pkg::S_FIN;
      end
      rau_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = rau_pkg::S_IDLE;
        end
      end
      default: state_d = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rau_pkg::S_FIN && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rau_pkg::S_IDLE && in_valid_i) begin
      act_q <= rau_pkg::act_e'(in_req_i.action);
      for (int i = 0; i < 4; i++) begin
        mag_q[i] <= in_mag[i];
        neg_q[i] <= in_neg[i];
      end
    end
    if (mul_en) begin
      prod_q[mul_idx] <= mul_p;
      pneg_q[mul_idx] <= mul_nx ^ mul_ny;
    end
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    ga_q   <= ga_d;
    gb_q   <= gb_d;
    g_q    <= g_d;
    rneg_q <= rneg_d && (nmag_d != '0);
    res_q  <= res_d;
    if (state_q == rau_pkg::S_FIN && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== rtl/rau_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module rau_div #(
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, quo_q, dvs_q;
  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
